[src/lrc_tp_pkg.sv]
// Package with the constants shared by the timestamp tag parser.
`default_nettype none

package lrc_tp_pkg;

    localparam int MAX_TAGS_PER_LINE = 16;
    localparam int TAG_CNT_W = $clog2(MAX_TAGS_PER_LINE + 1);

    localparam logic [2:0] MODE_EXPECT = 3'd0;
    localparam logic [2:0] MODE_MIN0   = 3'd1;
    localparam logic [2:0] MODE_MIN    = 3'd2;
    localparam logic [2:0] MODE_SEC0   = 3'd3;
    localparam logic [2:0] MODE_SEC    = 3'd4;
    localparam logic [2:0] MODE_FRAC   = 3'd5;
    localparam logic [2:0] MODE_DEAD   = 3'd6;

    localparam logic [7:0] CH_NEWLINE = 8'd10;
    localparam logic [7:0] CH_LBRACK  = 8'd91;
    localparam logic [7:0] CH_RBRACK  = 8'd93;
    localparam logic [7:0] CH_COLON   = 8'd58;
    localparam logic [7:0] CH_DOT     = 8'd46;
    localparam logic [7:0] BOM_0      = 8'hEF;
    localparam logic [7:0] BOM_1      = 8'hBB;
    localparam logic [7:0] BOM_2      = 8'hBF;

    localparam logic [1:0] BOM_DONE   = 2'd3;

    localparam logic [19:0] MIN_LIMIT = 20'd71582;
    localparam logic [9:0]  SEC_LIMIT = 10'd99;
    localparam logic [6:0]  SEC_WRAP  = 7'd60;
    localparam logic [2:0]  TOK_MIN   = 3'd4;

    localparam logic [32:0] MS_PER_MIN = 33'd60000;
    localparam logic [32:0] MS_PER_SEC = 33'd1000;

endpackage

`default_nettype wire

[src/lrc_timestamp_tag_parser.sv]
// Top level of the lyrics timestamp tag parser, one file byte per word.
// A tag result is registered and appears on the output in the cycle after its closing bracket is accepted.
// Throughput: one byte per cycle; the input stalls only while a result waits and is not taken.
// The output register sits between the channels, so a new byte is taken while a result waits
// only if that result is taken in the same cycle.
// Reset is synchronous and active low; it clears all line state and arms the byte-order mark skip.
`default_nettype none

module lrc_timestamp_tag_parser (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_in_valid,
    output logic             o_in_ready,
    input  wire logic [7:0]  i_data_byte,
    input  wire logic        i_file_start,
    output logic             o_out_valid,
    input  wire logic        i_out_ready,
    output logic [31:0]      o_time_ms,
    output logic [3:0]       o_tag_slot
);
    import lrc_tp_pkg::*;

    logic [2:0]           r_mode, n_mode;
    logic                 r_first, n_first;
    logic [1:0]           r_bom, n_bom;
    logic [16:0]          r_min, n_min;
    logic [6:0]           r_sec, n_sec;
    logic [9:0]           r_frac, n_frac;
    logic [1:0]           r_fcnt, n_fcnt;
    logic [2:0]           r_tok, n_tok;
    logic [TAG_CNT_W-1:0] r_tags, n_tags;
    logic                 r_out_valid;
    logic [31:0]          r_ms;
    logic [3:0]           r_slot;

    logic                 accept;
    logic                 emit;
    logic                 is_digit;
    logic [3:0]           digit;
    logic [19:0]          min_acc;
    logic [9:0]           sec_acc;
    logic [9:0]           frac_scaled;
    logic [32:0]          total;
    logic                 tag_ok;
    logic [31:0]          tags_ext;

    assign o_in_ready     = !r_out_valid || i_out_ready;
    assign accept         = i_in_valid && o_in_ready;
    assign o_out_valid    = r_out_valid;
    assign o_time_ms      = r_ms;
    assign o_tag_slot     = r_slot;

    assign is_digit = i_data_byte inside {[8'd48:8'd57]};
    assign digit    = i_data_byte[3:0];

    // The file-start clear also sends the mode back to expect, so no digit or closing bracket is
    // taken from that byte, and these values are taken from the registers as they are.
    assign min_acc = 20'(r_min) * 20'd10 + 20'(digit);
    assign sec_acc = 10'(r_sec) * 10'd10 + 10'(digit);

    always_comb begin
        case (r_fcnt)
            2'd1:    frac_scaled = 10'(r_frac * 10'd100);
            2'd2:    frac_scaled = 10'(r_frac * 10'd10);
            default: frac_scaled = r_frac;
        endcase
    end

    assign total  = 33'(r_min) * MS_PER_MIN + 33'(r_sec) * MS_PER_SEC + 33'(frac_scaled);
    assign tag_ok = (r_tok >= TOK_MIN) && !total[32];

    always_comb begin
        n_mode  = r_mode;
        n_first = r_first;
        n_bom   = r_bom;
        n_min   = r_min;
        n_sec   = r_sec;
        n_frac  = r_frac;
        n_fcnt  = r_fcnt;
        n_tok   = r_tok;
        n_tags  = r_tags;
        emit    = 1'b0;

        if (i_file_start) begin
            n_mode  = MODE_EXPECT;
            n_first = 1'b1;
            n_bom   = 2'd0;
            n_min   = '0;
            n_sec   = '0;
            n_frac  = '0;
            n_fcnt  = '0;
            n_tok   = '0;
            n_tags  = '0;
        end

        if (i_data_byte == CH_NEWLINE) begin
            n_mode  = MODE_EXPECT;
            n_first = 1'b0;
            n_bom   = 2'd0;
            n_min   = '0;
            n_sec   = '0;
            n_frac  = '0;
            n_fcnt  = '0;
            n_tok   = '0;
            n_tags  = '0;
        end else begin
            case (n_mode)
                MODE_EXPECT: begin
                    if (n_first && n_bom == 2'd0 && i_data_byte == BOM_0) begin
                        n_bom = 2'd1;
                    end else if (n_first && n_bom == 2'd1) begin
                        if (i_data_byte == BOM_1) begin
                            n_bom = 2'd2;
                        end else begin
                            n_mode = MODE_DEAD;
                        end
                    end else if (n_first && n_bom == 2'd2) begin
                        if (i_data_byte == BOM_2) begin
                            n_bom = BOM_DONE;
                        end else begin
                            n_mode = MODE_DEAD;
                        end
                    end else begin
                        if (n_first) begin
                            n_bom = BOM_DONE;
                        end
                        if (i_data_byte == CH_LBRACK) begin
                            n_mode = MODE_MIN0;
                            n_min  = '0;
                            n_sec  = '0;
                            n_frac = '0;
                            n_fcnt = '0;
                            n_tok  = '0;
                        end else begin
                            n_mode = MODE_DEAD;
                        end
                    end
                end
                MODE_MIN0, MODE_MIN: begin
                    if (is_digit) begin
                        if (min_acc > MIN_LIMIT) begin
                            n_mode = MODE_DEAD;
                        end else begin
                            n_min  = min_acc[16:0];
                            n_mode = MODE_MIN;
                            n_tok  = (r_tok < TOK_MIN) ? r_tok + 3'd1 : r_tok;
                        end
                    end else if (i_data_byte == CH_COLON && n_mode == MODE_MIN) begin
                        n_mode = MODE_SEC0;
                        n_tok  = (r_tok < TOK_MIN) ? r_tok + 3'd1 : r_tok;
                    end else begin
                        n_mode = MODE_DEAD;
                    end
                end
                MODE_SEC0, MODE_SEC: begin
                    if (is_digit) begin
                        if (sec_acc > SEC_LIMIT) begin
                            n_mode = MODE_DEAD;
                        end else begin
                            n_sec  = sec_acc[6:0];
                            n_mode = MODE_SEC;
                            n_tok  = (r_tok < TOK_MIN) ? r_tok + 3'd1 : r_tok;
                        end
                    end else if (n_mode == MODE_SEC && r_sec < SEC_WRAP
                                 && i_data_byte == CH_DOT) begin
                        n_mode = MODE_FRAC;
                        n_tok  = (r_tok < TOK_MIN) ? r_tok + 3'd1 : r_tok;
                    end else if (n_mode == MODE_SEC && r_sec < SEC_WRAP
                                 && i_data_byte == CH_RBRACK) begin
                        if (tag_ok) begin
                            n_mode = MODE_EXPECT;
                            emit   = 1'b1;
                        end else begin
                            n_mode = MODE_DEAD;
                        end
                    end else begin
                        n_mode = MODE_DEAD;
                    end
                end
                MODE_FRAC: begin
                    if (is_digit) begin
                        if (r_fcnt == 2'd3) begin
                            n_mode = MODE_DEAD;
                        end else begin
                            n_frac = 10'(r_frac * 10'd10 + 10'(digit));
                            n_fcnt = r_fcnt + 2'd1;
                            n_tok  = (r_tok < TOK_MIN) ? r_tok + 3'd1 : r_tok;
                        end
                    end else if (i_data_byte == CH_RBRACK && r_fcnt != 2'd0) begin
                        if (tag_ok) begin
                            n_mode = MODE_EXPECT;
                            emit   = 1'b1;
                        end else begin
                            n_mode = MODE_DEAD;
                        end
                    end else begin
                        n_mode = MODE_DEAD;
                    end
                end
                default: begin
                    n_mode = MODE_DEAD;
                end
            endcase

            if (emit) begin
                if (r_tags < TAG_CNT_W'(MAX_TAGS_PER_LINE)) begin
                    n_tags = r_tags + TAG_CNT_W'(1);
                end else begin
                    emit = 1'b0;
                end
            end
        end
    end

    assign tags_ext = 32'(r_tags);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode      <= MODE_EXPECT;
            r_first     <= 1'b1;
            r_bom       <= 2'd0;
            r_min       <= '0;
            r_sec       <= '0;
            r_frac      <= '0;
            r_fcnt      <= '0;
            r_tok       <= '0;
            r_tags      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (accept) begin
                r_mode  <= n_mode;
                r_first <= n_first;
                r_bom   <= n_bom;
                r_min   <= n_min;
                r_sec   <= n_sec;
                r_frac  <= n_frac;
                r_fcnt  <= n_fcnt;
                r_tok   <= n_tok;
                r_tags  <= n_tags;
            end
            if (accept && emit) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (accept && emit) begin
            r_ms   <= total[31:0];
            r_slot <= tags_ext[3:0];
        end
    end

endmodule

`default_nettype wire

[tb/sv/testbench.sv]
// Self-checking testbench for the lyrics timestamp tag parser with random idling on both sides.
`timescale 1ns / 1ps

module testbench;
    import lrc_tp_pkg::*;

    localparam int CYCLE_LIMIT  = 200000;
    localparam int RANDOM_BYTES = 1000;
    localparam int FRAC_DIGITS  = 3;

    localparam logic [1:0] BOM_NONE   = 2'd0;
    localparam logic [1:0] BOM_SAW_EF = 2'd1;
    localparam logic [1:0] BOM_SAW_BB = 2'd2;
    localparam logic [7:0] CH_DIGIT0  = 8'd48;
    localparam logic [7:0] CH_DIGIT9  = 8'd57;

    typedef struct packed {
        logic [7:0] data;
        logic       file_start;
    } t_lrc_word;

    typedef struct packed {
        logic [31:0] ms;
        logic [3:0]  slot;
    } t_tag_time;

    logic        i_clk;
    logic        i_rst_n      = 1'b0;
    logic        i_in_valid   = 1'b0;
    logic        o_in_ready;
    logic [7:0]  i_data_byte  = 8'd0;
    logic        i_file_start = 1'b0;
    logic        o_out_valid;
    logic        i_out_ready  = 1'b0;
    logic [31:0] o_time_ms;
    logic [3:0]  o_tag_slot;

    t_lrc_word   byte_stream_q[$];
    t_tag_time   tag_times_q[$];

    int unsigned send_idle_pct = 35;
    int unsigned take_idle_pct = 50;
    int unsigned cycle_count   = 0;
    int unsigned error_count   = 0;
    int unsigned bytes_queued  = 0;
    int unsigned bytes_sent    = 0;
    int unsigned lines_sent    = 0;
    int unsigned files_sent    = 0;
    int unsigned tags_checked  = 0;
    logic        start_next    = 1'b0;

    logic [2:0]  line_mode;
    logic        on_first_line;
    logic [1:0]  bom_seen;
    int unsigned minutes;
    int unsigned seconds;
    int unsigned frac_value;
    int unsigned frac_digits;
    int unsigned token_len;
    int unsigned tags_on_line;

    lrc_timestamp_tag_parser uut (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_in_valid     (i_in_valid),
        .o_in_ready     (o_in_ready),
        .i_data_byte    (i_data_byte),
        .i_file_start   (i_file_start),
        .o_out_valid    (o_out_valid),
        .i_out_ready    (i_out_ready),
        .o_time_ms      (o_time_ms),
        .o_tag_slot     (o_tag_slot)
    );

    always begin
        i_clk = 1'b0;
        #10;
        i_clk = 1'b1;
        #10;
    end

    task automatic clear_line_state();
        line_mode    = MODE_EXPECT;
        bom_seen     = BOM_NONE;
        minutes      = 0;
        seconds      = 0;
        frac_value   = 0;
        frac_digits  = 0;
        token_len    = 0;
        tags_on_line = 0;
    endtask

    task automatic parse_lrc_byte(input logic [7:0] b, input logic fs);
        logic            is_digit;
        logic            closing;
        int unsigned     v;
        int unsigned     frac_ms;
        longint unsigned total_ms;
        is_digit = (b >= CH_DIGIT0) && (b <= CH_DIGIT9);
        closing  = 1'b0;
        if (fs) begin
            clear_line_state();
            on_first_line = 1'b1;
        end
        if (b == CH_NEWLINE) begin
            clear_line_state();
            on_first_line = 1'b0;
            return;
        end
        case (line_mode)
            MODE_EXPECT: begin
                if (on_first_line && bom_seen != BOM_DONE) begin
                    if (bom_seen == BOM_NONE) begin
                        if (b == BOM_0) begin
                            bom_seen = BOM_SAW_EF;
                            return;
                        end
                        bom_seen = BOM_DONE;
                    end else if (bom_seen == BOM_SAW_EF) begin
                        if (b == BOM_1) bom_seen = BOM_SAW_BB;
                        else line_mode = MODE_DEAD;
                        return;
                    end else begin
                        if (b == BOM_2) bom_seen = BOM_DONE;
                        else line_mode = MODE_DEAD;
                        return;
                    end
                end
                if (b == CH_LBRACK) begin
                    line_mode   = MODE_MIN0;
                    minutes     = 0;
                    seconds     = 0;
                    frac_value  = 0;
                    frac_digits = 0;
                    token_len   = 0;
                end else begin
                    line_mode = MODE_DEAD;
                end
                return;
            end
            MODE_MIN0, MODE_MIN: begin
                if (is_digit) begin
                    v = minutes * 10 + (b - CH_DIGIT0);
                    if (v > MIN_LIMIT) begin
                        line_mode = MODE_DEAD;
                        return;
                    end
                    minutes   = v;
                    line_mode = MODE_MIN;
                end else if (b == CH_COLON && line_mode == MODE_MIN) begin
                    line_mode = MODE_SEC0;
                end else begin
                    line_mode = MODE_DEAD;
                    return;
                end
            end
            MODE_SEC0, MODE_SEC: begin
                if (is_digit) begin
                    v = seconds * 10 + (b - CH_DIGIT0);
                    if (v > SEC_LIMIT) begin
                        line_mode = MODE_DEAD;
                        return;
                    end
                    seconds   = v;
                    line_mode = MODE_SEC;
                end else if (line_mode == MODE_SEC && seconds < SEC_WRAP && b == CH_DOT) begin
                    line_mode = MODE_FRAC;
                end else if (line_mode == MODE_SEC && seconds < SEC_WRAP && b == CH_RBRACK) begin
                    closing = 1'b1;
                end else begin
                    line_mode = MODE_DEAD;
                    return;
                end
            end
            MODE_FRAC: begin
                if (is_digit) begin
                    if (frac_digits >= FRAC_DIGITS) begin
                        line_mode = MODE_DEAD;
                        return;
                    end
                    frac_value  = frac_value * 10 + (b - CH_DIGIT0);
                    frac_digits = frac_digits + 1;
                end else if (b == CH_RBRACK && frac_digits != 0) begin
                    closing = 1'b1;
                end else begin
                    line_mode = MODE_DEAD;
                    return;
                end
            end
            default: begin
                line_mode = MODE_DEAD;
                return;
            end
        endcase
        if (!closing) begin
            if (token_len < TOK_MIN) token_len = token_len + 1;
            return;
        end
        if (frac_digits == 1) frac_ms = frac_value * 100;
        else if (frac_digits == 2) frac_ms = frac_value * 10;
        else frac_ms = frac_value;
        total_ms = (64'(minutes) * 64'd60 + 64'(seconds)) * 64'd1000 + 64'(frac_ms);
        if (token_len < TOK_MIN || total_ms > 64'hFFFF_FFFF) begin
            line_mode = MODE_DEAD;
            return;
        end
        line_mode = MODE_EXPECT;
        if (tags_on_line < MAX_TAGS_PER_LINE) begin
            tag_times_q.push_back('{ms: total_ms[31:0], slot: tags_on_line[3:0]});
            tags_on_line = tags_on_line + 1;
        end
    endtask

    function automatic string dec_pad(input int unsigned v, input int unsigned w);
        string s;
        s = $sformatf("%0d", v);
        while (s.len() < w) s = {"0", s};
        return s;
    endfunction

    task automatic push_byte(input logic [7:0] b);
        byte_stream_q.push_back('{data: b, file_start: start_next});
        start_next   = 1'b0;
        bytes_queued = bytes_queued + 1;
    endtask

    task automatic push_text(input string s);
        for (int k = 0; k < s.len(); k++) push_byte(s[k]);
    endtask

    task automatic push_bom();
        push_byte(BOM_0);
        push_byte(BOM_1);
        push_byte(BOM_2);
    endtask

    task automatic push_random_tag(input logic well_formed);
        string       tag_txt;
        string       frac_txt;
        int unsigned pick;
        int unsigned mins;
        int unsigned secs;
        int unsigned ndig;
        int unsigned flaw;
        int unsigned pos;
        pick = $urandom_range(99);
        if (pick < 60) mins = $urandom_range(99);
        else if (pick < 85) mins = $urandom_range(9999);
        else mins = $urandom_range(MIN_LIMIT, 71000);
        secs = $urandom_range(59);
        ndig = $urandom_range(FRAC_DIGITS);
        frac_txt = "";
        if (ndig != 0) frac_txt = {".", dec_pad($urandom_range(10 ** ndig - 1), ndig)};
        flaw = well_formed ? 99 : $urandom_range(8);
        case (flaw)
            0: secs = $urandom_range(99, 60);
            1: secs = $urandom_range(999, 100);
            2: mins = $urandom_range(99999, 71583);
            3: frac_txt = {".", dec_pad($urandom_range(9999), 4)};
            4: frac_txt = ".";
            5: begin
                mins = MIN_LIMIT;
                secs = $urandom_range(59, 48);
            end
            default: ;
        endcase
        tag_txt = {"[", dec_pad(mins, $urandom_range(3, 1)), ":",
                   dec_pad(secs, $urandom_range(2, 1)), frac_txt, "]"};
        if (flaw >= 6 && flaw <= 8) begin
            pos = $urandom_range(tag_txt.len() - 1, 1);
            push_text(tag_txt.substr(0, pos - 1));
            if (flaw != 7) push_byte(8'($urandom_range(255)));
            if (flaw == 8) push_byte(tag_txt[pos]);
            push_text(tag_txt.substr(pos + 1, tag_txt.len() - 1));
        end else begin
            push_text(tag_txt);
        end
    endtask

    task automatic push_random_line();
        int unsigned kind;
        int unsigned ntags;
        kind = $urandom_range(99);
        if ($urandom_range(99) < 8) begin
            start_next = 1'b1;
            if ($urandom_range(1) != 0) push_bom();
        end
        if (kind < 70) begin
            ntags = ($urandom_range(19) == 0) ? $urandom_range(19, 15) : $urandom_range(4, 1);
            repeat (ntags) push_random_tag($urandom_range(9) != 0);
            repeat ($urandom_range(6)) push_byte(8'($urandom_range(126, 32)));
        end else if (kind < 85) begin
            repeat ($urandom_range(2)) push_random_tag(1'b1);
            push_random_tag(1'b0);
            repeat ($urandom_range(2)) push_random_tag(1'b1);
        end else begin
            repeat ($urandom_range(10, 1)) begin
                start_next = ($urandom_range(19) == 0);
                push_byte(8'($urandom_range(255)));
            end
        end
        push_byte(CH_NEWLINE);
    endtask

    always @(posedge i_clk) begin : byte_driver
        t_lrc_word w;
        if (!i_rst_n) begin
            i_in_valid <= 1'b0;
        end else begin
            if (i_in_valid && o_in_ready) begin
                parse_lrc_byte(i_data_byte, i_file_start);
                bytes_sent = bytes_sent + 1;
                if (i_data_byte == CH_NEWLINE) lines_sent = lines_sent + 1;
                if (i_file_start) files_sent = files_sent + 1;
            end
            if (!i_in_valid || o_in_ready) begin
                if (byte_stream_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    w = byte_stream_q.pop_front();
                    i_in_valid   <= 1'b1;
                    i_data_byte  <= w.data;
                    i_file_start <= w.file_start;
                end else begin
                    i_in_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin : tag_monitor
        t_tag_time want;
        if (!i_rst_n) begin
            i_out_ready <= 1'b0;
        end else begin
            if (o_out_valid && i_out_ready) begin
                if (tag_times_q.size() == 0) begin
                    $display("%0t: unexpected tag, expected none, actual ms=%0d slot=%0d",
                             $time, o_time_ms, o_tag_slot);
                    error_count = error_count + 1;
                end else begin
                    want = tag_times_q.pop_front();
                    tags_checked = tags_checked + 1;
                    if (o_time_ms !== want.ms) begin
                        $display("%0t: time_ms mismatch, expected %0d, actual %0d",
                                 $time, want.ms, o_time_ms);
                        error_count = error_count + 1;
                    end
                    if (o_tag_slot !== want.slot) begin
                        $display("%0t: tag_slot mismatch, expected %0d, actual %0d",
                                 $time, want.slot, o_tag_slot);
                        error_count = error_count + 1;
                    end
                end
            end
            i_out_ready <= ($urandom_range(99) >= take_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count == CYCLE_LIMIT) begin
            $display("%0t: timed out with %0d tags outstanding", $time, tag_times_q.size());
            $display("testbench: FAIL");
            $finish;
        end
    end

    initial begin
        int unsigned stop_at;
        clear_line_state();
        on_first_line = 1'b1;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        start_next = 1'b1;
        push_bom();
        push_text("[00:00][71582:47.295][1:02.5][1:02.05][1:02.345]la\n");
        push_text("[71582:47.296][1:23]\n");
        push_text("[71583:00][1:23]\n");
        push_text("[1:2][1:23]\n");
        push_text("[0:60]\n[0:99.1]\n[0:100]\n[1:02.]\n[1:02.1234]\n");
        push_text("[:12]\n[12]\n[1:]\n[1:0a]\n");
        push_text("[0:01]");
        push_byte(8'd0);
        push_text("[0:02]\n");
        push_text("[1:23\n[1:24]\nab[1:00]\n");
        push_bom();
        push_text("[0:05]\n");
        for (int k = 0; k < 18; k++) push_text({"[0:", dec_pad(k, 2), ".", dec_pad(k, 1), "]"});
        push_text("[0:61]\n");
        start_next = 1'b1;
        push_byte(BOM_0);
        push_byte(BOM_1);
        push_text("A[0:06]\n");
        start_next = 1'b1;
        push_byte(BOM_0);
        push_text("[0:06]\n");
        push_text("[0:07]");
        start_next = 1'b1;
        push_byte(CH_NEWLINE);
        push_bom();
        push_text("[0:08]\n");
        push_text("[1:00");
        start_next = 1'b1;
        push_text("[2:00]\n");
        start_next = 1'b1;
        push_text("[0:09.9]x\n");

        for (int phase = 0; phase < 3; phase++) begin
            send_idle_pct = (phase == 0) ? 35 : (phase == 1) ? 50 : 0;
            take_idle_pct = (phase == 0) ? 50 : (phase == 1) ? 35 : 0;
            stop_at = bytes_queued + RANDOM_BYTES / 3;
            while (bytes_queued < stop_at) push_random_line();
            while (byte_stream_q.size() != 0 || i_in_valid) @(posedge i_clk);
        end
        while (tag_times_q.size() != 0) @(posedge i_clk);
        repeat (10) @(posedge i_clk);

        $display("Sent %0d bytes in %0d lines across %0d file starts; %0d tag times compared.",
                 bytes_sent, lines_sent, files_sent, tags_checked);
        $display("Idle mixes: sender-heavy, receiver-heavy, then back-to-back; %0d errors.",
                 error_count);
        if (error_count == 0) begin
            $display("testbench: PASS");
        end else begin
            $display("testbench: FAIL");
        end
        $finish;
    end

endmodule

[files.f]
src/lrc_tp_pkg.sv
src/lrc_timestamp_tag_parser.sv
tb/sv/testbench.sv
